>>> rtl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> rtl/sobel_pkg.sv
// Types and constants of the Sobel edge and emboss filter.
package sobel_pkg;
   localparam logic [1:0] MODE_EDGE = 2'd0;
   localparam logic [1:0] MODE_EMBOSS = 2'd1;
   localparam logic [1:0] MODE_OVERLAY = 2'd2;
   localparam logic [1:0] REG_MODE = 2'd0;
   localparam logic [1:0] REG_WIDTH = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;
   localparam logic [1:0] REG_THRESH = 2'd3;
   localparam logic [23:0] BORDER_RGB = 24'h010101;
   localparam logic [10:0] WIDTH_RESET = 11'd640;
   localparam logic [10:0] HEIGHT_RESET = 11'd480;
   localparam logic [7:0] THRESH_RESET = 8'd50;
   localparam int SqrtSteps = 11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_GRAD,
      ST_SQRT,
      ST_FINISH,
      ST_OUT
   } state_type;
endpackage

>>> rtl/sobel_edge_emboss_filter.sv
// Sobel edge / emboss filter over an RGB pixel stream, one item at a time.
// An interior edge pixel runs the shared restoring square root, one bit a cycle; emboss
// modes and border pixels skip it. A pixel beat gives a result only once enough pixels
// are pending, and a flush beat gives one only while results are pending.
// Reset (synchronous, active high) clears window, positions, pending count; line memory kept.
`include "assert_macros.svh"
module sobel_edge_emboss_filter #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // pixel_in [23:0], overlay_pixel [47:24]
   input  logic        req_tuser,   // flush
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // pixel_out [23:0]
   output logic        rsp_tlast,   // end_of_frame
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int PW = $clog2(MAX_WIDTH + 3);

   sobel_pkg::state_type state_ff, state_in;

   logic [1:0]  mode_ff;
   logic [10:0] fwidth_ff, fheight_ff;
   logic [7:0]  thresh_ff;
   logic [23:0] pix_ff, ovl_ff;
   logic        flush_ff;
   logic [7:0]  win_ff [9];
   logic [7:0]  line0 [MAX_WIDTH];
   logic [7:0]  line1 [MAX_WIDTH];
   logic [7:0]  top_ff, mid_ff;
   logic [CW-1:0] in_col_ff, out_col_ff;
   logic [RW-1:0] in_row_ff, out_row_ff;
   logic [PW-1:0] pend_ff;
   logic signed [11:0] gx_ff, gy_ff;
   logic [20:0] rem_ff;
   logic [10:0] root_ff;
   logic [3:0]  step_ff;
   logic [23:0] out_data_ff;
   logic        out_last_ff;
   logic        emit_ff;

   // effective frame size
   logic [CW-1:0] w_eff;
   logic [RW-1:0] h_eff;
   always_comb begin
      if (fwidth_ff < 11'd3) w_eff = CW'(3);
      else if ({21'd0, fwidth_ff} > 32'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
      else w_eff = CW'(fwidth_ff);
      if (fheight_ff < 11'd3) h_eff = RW'(3);
      else if ({21'd0, fheight_ff} > 32'(MAX_HEIGHT)) h_eff = RW'(MAX_HEIGHT);
      else h_eff = RW'(fheight_ff);
   end

   logic [AW-1:0] addr;
   assign addr = in_col_ff[AW-1:0];

   logic [9:0] gsum;
   logic [19:0] gprod;
   logic [7:0] gray;
   assign gsum = 10'(pix_ff[23:16]) + 10'(pix_ff[15:8]) + 10'(pix_ff[7:0]);
   assign gprod = 20'(gsum) * 20'd683;
   assign gray = gprod[18:11];

   // gradients from the window
   logic signed [11:0] gx_c, gy_c;
   always_comb begin
      gx_c = 12'(win_ff[2]) + 12'({win_ff[5], 1'b0}) + 12'(win_ff[8])
           - 12'(win_ff[0]) - 12'({win_ff[3], 1'b0}) - 12'(win_ff[6]);
      gy_c = 12'(win_ff[6]) + 12'({win_ff[7], 1'b0}) + 12'(win_ff[8])
           - 12'(win_ff[0]) - 12'({win_ff[1], 1'b0}) - 12'(win_ff[2]);
   end

   logic border, last;
   always_comb begin
      border = (out_row_ff == '0) || (out_row_ff >= h_eff - RW'(1)) ||
               (out_col_ff == '0) || (out_col_ff >= w_eff - CW'(1));
      last = (out_row_ff >= h_eff - RW'(1)) && (out_col_ff >= w_eff - CW'(1));
   end

   // emboss value
   logic signed [11:0] esum, ehalf, eclamp;
   logic signed [9:0]  dlt;
   always_comb begin
      esum = gx_ff + gy_ff;
      ehalf = (esum + ((esum < 0) ? 12'sd1 : 12'sd0)) >>> 1;
      eclamp = ehalf + 12'sd128;
      if (eclamp < 12'sd1) eclamp = 12'sd1;
      else if (eclamp > 12'sd255) eclamp = 12'sd255;
      dlt = 10'(eclamp - 12'sd128);
   end

   function automatic logic [7:0] clamp_ch(input logic [7:0] c, input logic signed [9:0] d);
      logic signed [10:0] v;
      v = 11'(c) - 11'(d);
      if (v < 11'sd1) return 8'd1;
      if (v > 11'sd255) return 8'd255;
      return v[7:0];
   endfunction

   // one square-root step
   logic [20:0] trial, rem_next;
   logic [10:0] root_next;
   logic [21:0] bitv;
   always_comb begin
      bitv = 22'(1) << {step_ff, 1'b0};
      trial = 21'(({11'd0, root_ff} << (step_ff + 4'd1)) + bitv);
      if (rem_ff >= trial) begin
         rem_next = rem_ff - trial;
         root_next = root_ff | (11'd1 << step_ff);
      end else begin
         rem_next = rem_ff;
         root_next = root_ff;
      end
   end

   logic [21:0] sq_c;
   assign sq_c = 22'(gx_c) * 22'(gx_c) + 22'(gy_c) * 22'(gy_c);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sobel_pkg::ST_IDLE: if (req_tvalid) state_in = sobel_pkg::ST_READ;
         sobel_pkg::ST_READ: begin
            if (flush_ff && pend_ff == '0) state_in = sobel_pkg::ST_IDLE;
            else state_in = sobel_pkg::ST_GRAD;
         end
         sobel_pkg::ST_GRAD: begin
            if (!emit_ff) state_in = sobel_pkg::ST_IDLE;
            else if (border || mode_ff == sobel_pkg::MODE_EMBOSS ||
                     mode_ff == sobel_pkg::MODE_OVERLAY) state_in = sobel_pkg::ST_FINISH;
            else state_in = sobel_pkg::ST_SQRT;
         end
         sobel_pkg::ST_SQRT: if (step_ff == 4'd0) state_in = sobel_pkg::ST_FINISH;
         sobel_pkg::ST_FINISH: state_in = sobel_pkg::ST_OUT;
         sobel_pkg::ST_OUT: if (rsp_tready) state_in = sobel_pkg::ST_IDLE;
         default: state_in = sobel_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == sobel_pkg::ST_IDLE);
      rsp_tvalid = (state_ff == sobel_pkg::ST_OUT);
      csr_ready = 1'b1;
   end
   assign rsp_tdata = out_data_ff;
   assign rsp_tlast = out_last_ff;

   // line memory: read at capture, written back in the READ state that follows
   always_ff @(posedge clock) begin
      if (state_ff == sobel_pkg::ST_IDLE) begin
         top_ff <= line1[addr];
         mid_ff <= line0[addr];
      end
      if (state_ff == sobel_pkg::ST_READ && !flush_ff) begin
         line1[addr] <= mid_ff;
         line0[addr] <= gray;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sobel_pkg::ST_IDLE;
         mode_ff <= sobel_pkg::MODE_EDGE;
         fwidth_ff <= sobel_pkg::WIDTH_RESET;
         fheight_ff <= sobel_pkg::HEIGHT_RESET;
         thresh_ff <= sobel_pkg::THRESH_RESET;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
         in_col_ff <= '0;
         in_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pend_ff <= '0;
         emit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               sobel_pkg::REG_MODE: mode_ff <= csr_wdata[1:0];
               sobel_pkg::REG_WIDTH: fwidth_ff <= csr_wdata;
               sobel_pkg::REG_HEIGHT: fheight_ff <= csr_wdata;
               sobel_pkg::REG_THRESH: thresh_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (state_ff == sobel_pkg::ST_READ) begin
            if (flush_ff) begin
               emit_ff <= (pend_ff != '0);
            end else begin
               win_ff[0] <= win_ff[1];
               win_ff[1] <= win_ff[2];
               win_ff[2] <= top_ff;
               win_ff[3] <= win_ff[4];
               win_ff[4] <= win_ff[5];
               win_ff[5] <= mid_ff;
               win_ff[6] <= win_ff[7];
               win_ff[7] <= win_ff[8];
               win_ff[8] <= gray;
               if (in_col_ff + CW'(1) >= w_eff) begin
                  in_col_ff <= '0;
                  in_row_ff <= (in_row_ff + RW'(1) >= h_eff) ? '0 : in_row_ff + RW'(1);
               end else begin
                  in_col_ff <= in_col_ff + CW'(1);
               end
               pend_ff <= pend_ff + PW'(1);
               emit_ff <= ((PW+1)'(pend_ff) + (PW+1)'(1) > (PW+1)'(w_eff) + (PW+1)'(1));
            end
         end
         if (state_ff == sobel_pkg::ST_FINISH) begin
            if (out_col_ff + CW'(1) >= w_eff) begin
               out_col_ff <= '0;
               out_row_ff <= (out_row_ff + RW'(1) >= h_eff) ? '0 : out_row_ff + RW'(1);
            end else begin
               out_col_ff <= out_col_ff + CW'(1);
            end
            if (pend_ff != '0) pend_ff <= pend_ff - PW'(1);
         end
      end
   end

   logic [7:0] mag;
   always_comb begin
      if (root_ff < 11'(thresh_ff)) mag = 8'd0;
      else if (root_ff > 11'd255) mag = 8'd255;
      else mag = root_ff[7:0];
   end

   always_ff @(posedge clock) begin
      if (state_ff == sobel_pkg::ST_IDLE && req_tvalid) begin
         pix_ff <= req_tdata[23:0];
         ovl_ff <= req_tdata[47:24];
         flush_ff <= req_tuser;
      end
      // gradients from the window after this beat's shift
      if (state_ff == sobel_pkg::ST_GRAD) begin
         gx_ff <= gx_c;
         gy_ff <= gy_c;
         rem_ff <= 21'(sq_c);
         root_ff <= '0;
         step_ff <= 4'(sobel_pkg::SqrtSteps - 1);
      end
      if (state_ff == sobel_pkg::ST_SQRT) begin
         rem_ff <= rem_next;
         root_ff <= root_next;
         if (step_ff != 4'd0) step_ff <= step_ff - 4'd1;
      end
      if (state_ff == sobel_pkg::ST_FINISH) begin
         out_last_ff <= last;
         if (border) out_data_ff <= sobel_pkg::BORDER_RGB;
         else if (mode_ff == sobel_pkg::MODE_EMBOSS)
            out_data_ff <= {3{eclamp[7:0]}};
         else if (mode_ff == sobel_pkg::MODE_OVERLAY)
            out_data_ff <= {clamp_ch(ovl_ff[23:16], dlt), clamp_ch(ovl_ff[15:8], dlt),
                            clamp_ch(ovl_ff[7:0], dlt)};
         else out_data_ff <= {3{mag}};
      end
   end

   `ASSERT_IMPL(a_busy_no_ready, clock, reset,
      (state_ff != sobel_pkg::ST_IDLE) |-> !req_tready, "ready while busy")
   `ASSERT_IMPL(a_out_holds, clock, reset,
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && rsp_tvalid), "output moved")
   `ASSERT_IMPL(a_pend_bound, clock, reset,
      (PW+1)'(pend_ff) <= (PW+1)'(MAX_WIDTH) + (PW+1)'(2), "pending overflow")
   `ASSERT_IMPL(a_col_bound, clock, reset,
      (in_col_ff <= CW'(MAX_WIDTH)) && (out_col_ff <= CW'(MAX_WIDTH)), "column out of range")
endmodule
